[hw/rtl/two_axis_encoder_positioner_defines.svh]
// ----------------------------------------------------------------------------
// two_axis_encoder_positioner_defines
// assertion macros shared by the positioner rtl
// ----------------------------------------------------------------------------
`ifndef TWO_AXIS_ENCODER_POSITIONER_DEFINES_SVH
`define TWO_AXIS_ENCODER_POSITIONER_DEFINES_SVH

// same-cycle implication under async reset
`define TEP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tep assertion failed");

// next-cycle implication under async reset
`define TEP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tep assertion failed");

`endif

[hw/rtl/tep_pkg.sv]
// ----------------------------------------------------------------------------
// tep_pkg
// shared types and constants of the two-axis encoder positioner
// ----------------------------------------------------------------------------
package tep_pkg;

	// default signed position width
	localparam int POS_WIDTH_DEF = 17;

	// target and limit width
	localparam int TGT_WIDTH = 16;

	// reset value of the target limit register
	localparam logic [TGT_WIDTH-1:0] MAX_POSITION_RST = 16'd31745;

	// item opcodes
	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_MOVE   = 1'b1
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_BUSY  = 2'd2
	} status_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_MAX_POSITION = 2'd0,
		CFG_X_INVERT     = 2'd1,
		CFG_Y_INVERT     = 2'd2
	} cfg_idx_t;

	// per-axis control from the top level
	typedef struct packed {
		logic load;    // item transfer this cycle
		logic sample;  // item is a pin sample
		logic count;   // sample with previous levels held
		logic move;    // accepted move that includes this axis
		logic invert;  // reverse counting direction
	} axis_ctl_t;

	// per-axis status back to the top level
	typedef struct packed {
		logic forward;
		logic drive;
		logic drive_next;
	} axis_sts_t;

endpackage

[hw/rtl/tep_cmd_if.sv]
// ----------------------------------------------------------------------------
// tep_cmd_if
// item channel: pin samples and move commands
// ----------------------------------------------------------------------------
interface tep_cmd_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic        x_a;
	logic        x_b;
	logic        y_a;
	logic        y_b;
	logic        move_x_enable;
	logic        move_y_enable;
	logic [15:0] x_target;
	logic [15:0] y_target;

	modport source (
		output valid, op, x_a, x_b, y_a, y_b, move_x_enable, move_y_enable,
			x_target, y_target,
		input  ready
	);

	modport sink (
		input  valid, op, x_a, x_b, y_a, y_b, move_x_enable, move_y_enable,
			x_target, y_target,
		output ready
	);
endinterface

[hw/rtl/tep_res_if.sv]
// ----------------------------------------------------------------------------
// tep_res_if
// result channel: positions, drive state and move status
// ----------------------------------------------------------------------------
interface tep_res_if #(
	parameter int POS_WIDTH = tep_pkg::POS_WIDTH_DEF
);
	logic                        valid;
	logic                        ready;
	logic signed [POS_WIDTH-1:0] x_count;
	logic signed [POS_WIDTH-1:0] y_count;
	logic                        x_forward;
	logic                        y_forward;
	logic                        x_drive;
	logic                        y_drive;
	logic                        busy_res;
	logic                        move_done;
	logic [1:0]                  status;

	modport source (
		output valid, x_count, y_count, x_forward, y_forward, x_drive, y_drive,
			busy_res, move_done, status,
		input  ready
	);

	modport sink (
		input  valid, x_count, y_count, x_forward, y_forward, x_drive, y_drive,
			busy_res, move_done, status,
		output ready
	);
endinterface

[hw/rtl/tep_axis.sv]
// ----------------------------------------------------------------------------
// tep_axis
// one axis: x4 quadrature counter with saturation, goal and run state
// ----------------------------------------------------------------------------
module tep_axis #(
	parameter int POS_WIDTH = tep_pkg::POS_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tep_pkg::axis_ctl_t                 ctl,
	input  logic                               pin_a,
	input  logic                               pin_b,
	input  logic [tep_pkg::TGT_WIDTH-1:0]      target,
	output logic signed [POS_WIDTH-1:0]        pos,
	output tep_pkg::axis_sts_t                 sts
);
	import tep_pkg::*;

	// compare width: holds the signed position and the unsigned goal
	localparam int CW = (POS_WIDTH > TGT_WIDTH) ? POS_WIDTH : TGT_WIDTH + 1;
	localparam logic signed [POS_WIDTH-1:0] P_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
	localparam logic signed [POS_WIDTH-1:0] P_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};
	localparam logic [POS_WIDTH-1:0]        P_ONE = {{(POS_WIDTH-1){1'b0}}, 1'b1};

	logic signed [POS_WIDTH-1:0] pos_q;
	logic [TGT_WIDTH-1:0]        goal_q;
	logic                        fwd_q;
	logic                        run_q;
	logic                        pa_q;
	logic                        pb_q;

	logic                        a_chg;
	logic                        b_chg;
	logic                        up_raw;
	logic                        step;
	logic                        inc;
	logic                        dec;
	logic signed [POS_WIDTH-1:0] pos_cnt;
	logic signed [CW-1:0]        pos_ext;
	logic signed [CW-1:0]        cnt_ext;
	logic signed [CW-1:0]        goal_ext;
	logic signed [CW-1:0]        tgt_ext;
	logic                        reached;
	logic                        fwd_new;
	logic                        run_new;

	// quadrature step: a lone edge on one channel, both edges cancel
	always_comb begin
		a_chg  = pin_a != pa_q;
		b_chg  = pin_b != pb_q;
		step   = ctl.count && (a_chg ^ b_chg);
		up_raw = a_chg ? (pin_a == pin_b) : (pin_a != pin_b);
		inc    = step && (up_raw ^ ctl.invert);
		dec    = step && !(up_raw ^ ctl.invert);
	end

	// saturating count
	always_comb begin
		pos_cnt = pos_q;
		if (inc && pos_q != P_MAX) begin
			pos_cnt = pos_q + P_ONE;
		end else if (dec && pos_q != P_MIN) begin
			pos_cnt = pos_q - P_ONE;
		end
	end

	// goal compares
	assign pos_ext  = CW'(pos_q);
	assign cnt_ext  = CW'(pos_cnt);
	assign goal_ext = CW'(goal_q);
	assign tgt_ext  = CW'(target);
	assign reached  = fwd_q ? (cnt_ext >= goal_ext) : (cnt_ext <= goal_ext);
	assign fwd_new  = tgt_ext > pos_ext;
	assign run_new  = ctl.move ? (tgt_ext != pos_ext) : (run_q && !reached);

	// axis state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			goal_q <= '0;
			fwd_q  <= 1'b0;
			run_q  <= 1'b0;
			pa_q   <= 1'b0;
			pb_q   <= 1'b0;
		end else if (ctl.load) begin
			pos_q <= pos_cnt;
			run_q <= run_new;
			if (ctl.sample) begin
				pa_q <= pin_a;
				pb_q <= pin_b;
			end
			if (ctl.move) begin
				goal_q <= target;
				fwd_q  <= fwd_new;
			end
		end
	end

	assign pos            = pos_q;
	assign sts.forward    = fwd_q;
	assign sts.drive      = run_q;
	assign sts.drive_next = run_new;

endmodule

[hw/rtl/two_axis_encoder_positioner.sv]
// ----------------------------------------------------------------------------
// two_axis_encoder_positioner
// two-axis point-to-point positioner with x4 quadrature decoding
// ----------------------------------------------------------------------------
//  channel  dir  contents
//  cmd      in   op, encoder levels, move enables and targets
//  res      out  counts, directions, drives, busy, move done, status
//  cfg      in   write enable, register index, 16-bit data
//
//  one item per clock while res is not stalled; each result is registered on its transfer
//  the axis state registers double as the result register, so a new item is
//  taken in the same cycle the pending result is transferred
//  a stalled result holds cmd off; reset initializes all state, no clearing pass
// ----------------------------------------------------------------------------
`include "two_axis_encoder_positioner_defines.svh"

module two_axis_encoder_positioner #(
	parameter int POS_WIDTH = tep_pkg::POS_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [tep_pkg::TGT_WIDTH-1:0]     cfg_data,
	tep_cmd_if.sink                           cmd,
	tep_res_if.source                         res
);
	import tep_pkg::*;

	logic [TGT_WIDTH-1:0] max_pos_q;
	logic                 x_inv_q;
	logic                 y_inv_q;
	logic                 captured_q;
	logic                 valid_q;
	logic                 done_q;
	status_t              status_q;

	logic                 in_xfer;
	logic                 is_move;
	logic                 busy;
	logic                 range_err;
	logic                 move_ok;
	logic                 done_new;
	status_t              status_new;
	axis_ctl_t            x_ctl;
	axis_ctl_t            y_ctl;
	axis_sts_t            x_sts;
	axis_sts_t            y_sts;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pos_q <= MAX_POSITION_RST;
			x_inv_q   <= 1'b0;
			y_inv_q   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_POSITION: max_pos_q <= cfg_data;
				CFG_X_INVERT:     x_inv_q   <= cfg_data[0];
				CFG_Y_INVERT:     y_inv_q   <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// handshake: take an item whenever the result slot is free or draining
	assign cmd.ready = !valid_q || res.ready;
	assign in_xfer   = cmd.valid && cmd.ready;

	// move checks: busy first, then range
	assign is_move   = cmd.op == OP_MOVE;
	assign busy      = x_sts.drive || y_sts.drive;
	assign range_err = (cmd.move_x_enable && cmd.x_target > max_pos_q) ||
		(cmd.move_y_enable && cmd.y_target > max_pos_q);
	assign move_ok   = is_move && !busy && !range_err;

	always_comb begin
		status_new = ST_OK;
		if (is_move && busy) begin
			status_new = ST_BUSY;
		end else if (is_move && range_err) begin
			status_new = ST_RANGE;
		end
	end

	// done when a move starts nothing or the last running axis stops
	assign done_new = (move_ok || busy) && !x_sts.drive_next && !y_sts.drive_next;

	// axis controls
	always_comb begin
		x_ctl.load   = in_xfer;
		x_ctl.sample = !is_move;
		x_ctl.count  = !is_move && captured_q;
		x_ctl.move   = move_ok && cmd.move_x_enable;
		x_ctl.invert = x_inv_q;
		y_ctl        = x_ctl;
		y_ctl.move   = move_ok && cmd.move_y_enable;
		y_ctl.invert = y_inv_q;
	end

	tep_axis #(
		.POS_WIDTH (POS_WIDTH)
	) u_x_axis (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (x_ctl),
		.pin_a  (cmd.x_a),
		.pin_b  (cmd.x_b),
		.target (cmd.x_target),
		.pos    (res.x_count),
		.sts    (x_sts)
	);

	tep_axis #(
		.POS_WIDTH (POS_WIDTH)
	) u_y_axis (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (y_ctl),
		.pin_a  (cmd.y_a),
		.pin_b  (cmd.y_b),
		.target (cmd.y_target),
		.pos    (res.y_count),
		.sts    (y_sts)
	);

	// result slot and first-sample flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			done_q     <= 1'b0;
			status_q   <= ST_OK;
			captured_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				valid_q  <= 1'b1;
				done_q   <= done_new;
				status_q <= status_new;
				if (!is_move) begin
					captured_q <= 1'b1;
				end
			end else if (res.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// result fields
	assign res.valid     = valid_q;
	assign res.x_forward = x_sts.forward;
	assign res.y_forward = y_sts.forward;
	assign res.x_drive   = x_sts.drive;
	assign res.y_drive   = y_sts.drive;
	assign res.busy_res  = busy;
	assign res.move_done = done_q;
	assign res.status    = status_q;

	// a finished move leaves no axis running
	`TEP_ASSERT_IMP(a_done_idle, clk, arst_n, valid_q && done_q, !busy)
	// a rejected move never reports done
	`TEP_ASSERT_IMP(a_reject_no_done, clk, arst_n, valid_q && status_q != ST_OK, !done_q)
	// a move command never changes the counts
	`TEP_ASSERT_NXT(a_move_keeps_count, clk, arst_n, in_xfer && is_move,
		$stable(res.x_count) && $stable(res.y_count))
	// a move refused while busy leaves drive and direction alone
	`TEP_ASSERT_NXT(a_busy_hold, clk, arst_n, in_xfer && is_move && busy,
		$stable(x_sts.forward) && $stable(x_sts.drive) && $stable(y_sts.forward) && $stable(y_sts.drive))

endmodule
